[rtl/hsa_pkg.sv]
// Shared types and constants of the handle slot allocator.
`default_nettype none

package hsa_pkg;

  // Command codes carried in the cmd field of a request word.
  typedef enum logic [1:0] {
    CMD_REG    = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_GRAB   = 2'd2,
    CMD_RETIRE = 2'd3
  } cmd_t;

  // Status codes returned with every response word.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // Bit positions of the thread and node numbers inside a handle.
  localparam int unsigned THREAD_SHIFT = 32;
  localparam int unsigned HARBOR_SHIFT = 40;

  localparam int unsigned HANDLE_W = 48;
  localparam int unsigned CTX_W    = 32;
  localparam int unsigned ID_W     = 8;

  // One slot of the table as kept in memory.
  typedef struct packed {
    logic                valid;
    logic [HANDLE_W-1:0] handle;
    logic [CTX_W-1:0]    ctx;
  } slot_entry_t;

  // One response word.
  typedef struct packed {
    logic [1:0]          status;
    logic [HANDLE_W-1:0] handle_out;
    logic [CTX_W-1:0]    ctx_out;
  } rsp_word_t;

endpackage

`default_nettype wire

[rtl/hsa_cmd_if.sv]
// Request channel of the handle slot allocator.
`default_nettype none

interface hsa_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] ctx_value;
  logic [7:0]  thread_id;
  logic [47:0] handle_in;

  modport source (output valid, cmd, ctx_value, thread_id, handle_in, input ready);
  modport sink   (input valid, cmd, ctx_value, thread_id, handle_in, output ready);
endinterface

`default_nettype wire

[rtl/hsa_rsp_if.sv]
// Response channel of the handle slot allocator.
`default_nettype none

interface hsa_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [47:0] handle_out;
  logic [31:0] ctx_out;

  modport source (output valid, status, handle_out, ctx_out, input ready);
  modport sink   (input valid, status, handle_out, ctx_out, output ready);
endinterface

`default_nettype wire

[rtl/hsa_slot_mem.sv]
// Slot table memory: one write port, one read port, registered read data.
`default_nettype none

module hsa_slot_mem #(
  parameter int unsigned ADDR_BITS = 10
) (
  input  wire logic                 clk,
  input  wire logic                 wr_en,
  input  wire logic [ADDR_BITS-1:0] wr_addr,
  input  wire hsa_pkg::slot_entry_t wr_data,
  input  wire logic                 rd_en,
  input  wire logic [ADDR_BITS-1:0] rd_addr,
  output hsa_pkg::slot_entry_t      rd_data
);

  hsa_pkg::slot_entry_t mem [2**ADDR_BITS];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; the read data is registered.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[rtl/hsa_ctrl.sv]
// Sequencer: clearing pass, slot lookup and free-slot scan over the slot memory.
`default_nettype none

module hsa_ctrl #(
  parameter int unsigned SLOT_BITS  = 10,
  parameter int unsigned LOCAL_BITS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  hsa_cmd_if.sink                   req,
  input  wire logic [7:0]           harbor,
  output logic                      res_valid,
  output hsa_pkg::rsp_word_t        res,
  input  wire logic                 res_take,
  output logic                      mem_wr_en,
  output logic [SLOT_BITS-1:0]      mem_wr_addr,
  output hsa_pkg::slot_entry_t      mem_wr_data,
  output logic                      mem_rd_en,
  output logic [SLOT_BITS-1:0]      mem_rd_addr,
  input  wire hsa_pkg::slot_entry_t mem_rd_data
);

  localparam logic [SLOT_BITS-1:0] LAST_SLOT = '1;

  typedef enum logic [3:0] {
    S_CLEAR  = 4'b0001,
    S_IDLE   = 4'b0010,
    S_LOOKUP = 4'b0100,
    S_SCAN   = 4'b1000
  } state_t;

  state_t                state, state_next;
  logic [SLOT_BITS-1:0]  clr_addr;
  logic [LOCAL_BITS-1:0] next_local, next_local_next;
  logic [LOCAL_BITS-1:0] chk_local, chk_local_next;
  logic [SLOT_BITS-1:0]  probes, probes_next;
  hsa_pkg::cmd_t         cmd_q;
  logic [31:0]           ctx_q;
  logic [7:0]            thread_q;
  logic [47:0]           hin_q;
  hsa_pkg::rsp_word_t    res_next;
  logic                  res_valid_next;

  logic                  accept;
  logic [LOCAL_BITS-1:0] local_inc;
  logic [LOCAL_BITS-1:0] local_step;
  logic [47:0]           chk_ext;
  logic [47:0]           step_ext;
  logic [47:0]           nl_ext;
  logic [63:0]           enc_wide;
  logic [47:0]           enc;
  logic                  holds;

  // Local index arithmetic; zero is reserved, so a wrap lands on one.
  always_comb begin
    local_inc  = chk_local + LOCAL_BITS'(1);
    local_step = (local_inc == '0) ? LOCAL_BITS'(1) : local_inc;
    chk_ext    = 48'(chk_local);
    step_ext   = 48'(local_step);
    nl_ext     = 48'(next_local);
    enc_wide   = 64'(chk_local)
               | (64'(harbor) << hsa_pkg::HARBOR_SHIFT)
               | (64'(thread_q) << hsa_pkg::THREAD_SHIFT);
    enc        = enc_wide[47:0];
    holds      = mem_rd_data.valid && (mem_rd_data.handle == hin_q);
  end

  // One word in flight at a time; the next is taken once the result slot is free.
  assign req.ready = (state == S_IDLE) && !res_valid;
  assign accept    = req.valid && req.ready;

  // Next-state, memory access and result logic.
  always_comb begin
    state_next      = state;
    next_local_next = next_local;
    chk_local_next  = chk_local;
    probes_next     = probes;
    res_next        = res;
    res_valid_next  = res_valid && !res_take;
    mem_wr_en       = 1'b0;
    mem_wr_addr     = hin_q[SLOT_BITS-1:0];
    mem_wr_data     = mem_rd_data;
    mem_rd_en       = 1'b0;
    mem_rd_addr     = req.handle_in[SLOT_BITS-1:0];

    case (state)
      S_CLEAR: begin
        mem_wr_en         = 1'b1;
        mem_wr_addr       = clr_addr;
        mem_wr_data       = '0;
        if (clr_addr == LAST_SLOT) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          mem_rd_en = 1'b1;
          if (hsa_pkg::cmd_t'(req.cmd) == hsa_pkg::CMD_REG) begin
            mem_rd_addr    = nl_ext[SLOT_BITS-1:0];
            chk_local_next = next_local;
            probes_next    = '0;
            state_next     = S_SCAN;
          end else begin
            state_next = S_LOOKUP;
          end
        end
      end

      S_SCAN: begin
        // Data for chk_local arrives now; the read of the following index goes out.
        mem_rd_en      = 1'b1;
        mem_rd_addr    = step_ext[SLOT_BITS-1:0];
        chk_local_next = local_step;
        probes_next    = probes + SLOT_BITS'(1);
        if (!mem_rd_data.valid) begin
          mem_wr_en          = 1'b1;
          mem_wr_addr        = chk_ext[SLOT_BITS-1:0];
          mem_wr_data.valid  = 1'b1;
          mem_wr_data.handle = enc;
          mem_wr_data.ctx    = ctx_q;
          next_local_next    = local_step;
          res_next.status     = hsa_pkg::ST_OK;
          res_next.handle_out = enc;
          res_next.ctx_out    = '0;
          res_valid_next      = 1'b1;
          state_next          = S_IDLE;
        end else if (probes == LAST_SLOT) begin
          res_next.status     = hsa_pkg::ST_FULL;
          res_next.handle_out = '0;
          res_next.ctx_out    = '0;
          res_valid_next      = 1'b1;
          state_next          = S_IDLE;
        end
      end

      S_LOOKUP: begin
        res_next.status     = hsa_pkg::ST_MISS;
        res_next.handle_out = '0;
        res_next.ctx_out    = '0;
        res_valid_next      = 1'b1;
        state_next          = S_IDLE;
        case (cmd_q)
          hsa_pkg::CMD_ADD: begin
            if (holds) begin
              res_next.status = hsa_pkg::ST_MISS;
            end else if (mem_rd_data.valid) begin
              res_next.status = hsa_pkg::ST_FULL;
            end else begin
              mem_wr_en          = 1'b1;
              mem_wr_data.valid  = 1'b1;
              mem_wr_data.handle = hin_q;
              mem_wr_data.ctx    = ctx_q;
              res_next.status    = hsa_pkg::ST_OK;
            end
          end
          hsa_pkg::CMD_GRAB: begin
            if (holds) begin
              res_next.status  = hsa_pkg::ST_OK;
              res_next.ctx_out = mem_rd_data.ctx;
            end
          end
          hsa_pkg::CMD_RETIRE: begin
            if (holds) begin
              mem_wr_en         = 1'b1;
              mem_wr_data.valid = 1'b0;
              res_next.status   = hsa_pkg::ST_OK;
            end
          end
          default: begin
            res_next.status = hsa_pkg::ST_MISS;
          end
        endcase
      end

      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      next_local <= LOCAL_BITS'(1);
      res_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      clr_addr   <= clr_addr + SLOT_BITS'(1);
      next_local <= next_local_next;
      res_valid  <= res_valid_next;
    end
  end

  // Request and scan payload registers.
  always_ff @(posedge clk) begin
    chk_local <= chk_local_next;
    probes    <= probes_next;
    res       <= res_next;
    if (accept) begin
      cmd_q    <= hsa_pkg::cmd_t'(req.cmd);
      ctx_q    <= req.ctx_value;
      thread_q <= req.thread_id;
      hin_q    <= req.handle_in;
    end
  end

endmodule

`default_nettype wire

[rtl/handle_slot_allocator_unit.sv]
// Top level of the handle slot allocator: node register, sequencer, memory, output stage.
//
// Usage: request words (cmd, ctx_value, thread_id, handle_in) arrive on req and one
// response word (status, handle_out, ctx_out) leaves on rsp for each request, in order.
// Both channels move a word when valid and ready are high at a rising edge of clk.
// The user must write the node number through cfg_wr_en / cfg_wr_data only while the
// block is idle; the block itself does not enforce it. The table has 2**SLOT_BITS
// slots kept in one single-port-read memory. Add, grab and retire read the slot, then
// pass the result through the internal result register to the output register.
// Register streams one slot probe per cycle through the memory read port until it
// finds a free slot, and gives up with status full after 2**SLOT_BITS probed slots.
// One request is worked at a time; the next is accepted once the result has moved
// into the output register, so it overlaps a response still waiting on rsp.
// Reset (rst, synchronous) empties the table with a clearing pass over every slot,
// during which req.ready stays low; the node number resets to 0 and the
// running local index to 1.
// When rsp is stalled, the output word holds; one more result is kept inside and
// further requests wait.
`default_nettype none

module handle_slot_allocator_unit #(
  parameter int unsigned SLOT_BITS  = 10,
  parameter int unsigned LOCAL_BITS = 32
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data,
  hsa_cmd_if.sink         req,
  hsa_rsp_if.source       rsp
);

  logic [7:0]           harbor;
  logic                 res_valid;
  hsa_pkg::rsp_word_t   res;
  logic                 res_take;
  logic                 mem_wr_en;
  logic [SLOT_BITS-1:0] mem_wr_addr;
  hsa_pkg::slot_entry_t mem_wr_data;
  logic                 mem_rd_en;
  logic [SLOT_BITS-1:0] mem_rd_addr;
  hsa_pkg::slot_entry_t mem_rd_data;

  // Node number register.
  always_ff @(posedge clk) begin
    if (rst) begin
      harbor <= '0;
    end else if (cfg_wr_en) begin
      harbor <= cfg_wr_data;
    end
  end

  hsa_ctrl #(
    .SLOT_BITS  (SLOT_BITS),
    .LOCAL_BITS (LOCAL_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .harbor      (harbor),
    .res_valid   (res_valid),
    .res         (res),
    .res_take    (res_take),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  hsa_slot_mem #(
    .ADDR_BITS (SLOT_BITS)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // Output register: loads when empty or when its word is being taken.
  assign res_take = res_valid && (!rsp.valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (res_take) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      rsp.status     <= res.status;
      rsp.handle_out <= res.handle_out;
      rsp.ctx_out    <= res.ctx_out;
    end
  end

endmodule

`default_nettype wire

[rtl/hsa_checker.sv]
// Port-level checks of the handle slot allocator and their binding to the top level.
`default_nettype none

module hsa_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        req_ready,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic [1:0]  rsp_status,
  input wire logic [47:0] rsp_handle_out,
  input wire logic [31:0] rsp_ctx_out
);

  // A stalled response word stays offered.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response word dropped while stalled");

  // The clearing pass keeps requests out right after reset.
  a_clear_blocks: assert property (@(posedge clk)
    rst |=> !req_ready)
    else $error("request accepted during clearing pass");

  // Only the three defined status codes are produced.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_status == hsa_pkg::ST_OK) || (rsp_status == hsa_pkg::ST_MISS) ||
                  (rsp_status == hsa_pkg::ST_FULL))
    else $error("undefined status code");

  // A failed command carries no handle and no context.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status != hsa_pkg::ST_OK) |-> (rsp_handle_out == '0) &&
                                                   (rsp_ctx_out == '0))
    else $error("failed command returned data");

endmodule

bind handle_slot_allocator_unit hsa_checker u_hsa_checker (
  .clk            (clk),
  .rst            (rst),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_status     (rsp.status),
  .rsp_handle_out (rsp.handle_out),
  .rsp_ctx_out    (rsp.ctx_out)
);

`default_nettype wire

[sim/tb_top.sv]
// Self-checking testbench for the handle slot allocator: random and directed table traffic.
`default_nettype none

module tb_top;

  localparam int unsigned SLOT_BITS   = 10;
  localparam int unsigned SLOT_COUNT  = 1 << SLOT_BITS;
  localparam logic [63:0] LOCAL_LIMIT = 64'hFFFF_FFFF;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned BACKLOG_MAX = 4;

  // One request word waiting to be offered.
  typedef struct {
    hsa_pkg::cmd_t op;
    logic [31:0]   ctx;
    logic [7:0]    thread;
    logic [47:0]   handle;
  } table_req_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_wr_en;
  logic [7:0] cfg_wr_data;

  hsa_cmd_if req_bus ();
  hsa_rsp_if rsp_bus ();

  handle_slot_allocator_unit dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req         (req_bus),
    .rsp         (rsp_bus)
  );

  // Shadow copy of the slot table, the running local index and the node number.
  logic        tbl_valid  [SLOT_COUNT];
  logic [47:0] tbl_handle [SLOT_COUNT];
  logic [31:0] tbl_ctx    [SLOT_COUNT];
  logic [31:0] local_cursor;
  logic [7:0]  node_id;

  table_req_t          req_backlog[$];
  hsa_pkg::rsp_word_t  expected_rsp[$];

  int unsigned cycle_count   = 0;
  int unsigned err_count     = 0;
  int          req_gap       = 0;
  int          req_calm      = 0;
  int          rsp_stall     = 0;
  int          rsp_calm      = 0;
  int          rsp_hold_left = 0;
  bit          req_taken     = 1'b0;
  bit          rsp_taken     = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Gap length: mostly none or short, now and then long, with calm stretches.
  function automatic int pick_gap(inout int calm_left);
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm_left = $urandom_range(10, 40);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [47:0] rand48();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[47:0];
  endfunction

  // Applies one request to the shadow table and returns the response word it should yield.
  function automatic hsa_pkg::rsp_word_t predict_table_op(input hsa_pkg::cmd_t op,
                                                          input logic [31:0] ctx,
                                                          input logic [7:0] thread,
                                                          input logic [47:0] hin);
    hsa_pkg::rsp_word_t w;
    logic [63:0]        idx;
    logic [63:0]        enc;
    int unsigned        s;
    int unsigned        i;
    bit                 done;
    w.status     = hsa_pkg::ST_MISS;
    w.handle_out = '0;
    w.ctx_out    = '0;
    s = hin[SLOT_BITS-1:0];
    case (op)
      hsa_pkg::CMD_REG: begin
        // Probe from the running index; the index skips zero and wraps to one.
        w.status = hsa_pkg::ST_FULL;
        idx      = 64'(local_cursor);
        done     = 1'b0;
        for (i = 0; i < SLOT_COUNT && !done; i++) begin
          if (idx > LOCAL_LIMIT || idx == 0) idx = 64'd1;
          s = idx[SLOT_BITS-1:0];
          if (!tbl_valid[s]) begin
            enc = idx | (64'(node_id) << hsa_pkg::HARBOR_SHIFT)
                | (64'(thread) << hsa_pkg::THREAD_SHIFT);
            local_cursor  = (idx + 1 > LOCAL_LIMIT) ? 32'd1 : idx[31:0] + 32'd1;
            tbl_valid[s]  = 1'b1;
            tbl_handle[s] = enc[47:0];
            tbl_ctx[s]    = ctx;
            w.handle_out  = enc[47:0];
            w.status      = hsa_pkg::ST_OK;
            done          = 1'b1;
          end else begin
            idx++;
          end
        end
      end
      hsa_pkg::CMD_ADD: begin
        if (tbl_valid[s] && tbl_handle[s] == hin) begin
          w.status = hsa_pkg::ST_MISS;
        end else if (tbl_valid[s]) begin
          w.status = hsa_pkg::ST_FULL;
        end else begin
          tbl_valid[s]  = 1'b1;
          tbl_handle[s] = hin;
          tbl_ctx[s]    = ctx;
          w.status      = hsa_pkg::ST_OK;
        end
      end
      hsa_pkg::CMD_GRAB: begin
        if (tbl_valid[s] && tbl_handle[s] == hin) begin
          w.ctx_out = tbl_ctx[s];
          w.status  = hsa_pkg::ST_OK;
        end
      end
      default: begin
        if (tbl_valid[s] && tbl_handle[s] == hin) begin
          tbl_valid[s] = 1'b0;
          w.status     = hsa_pkg::ST_OK;
        end
      end
    endcase
    return w;
  endfunction

  function automatic void report_mismatch(input string what, input hsa_pkg::rsp_word_t want,
                                          input hsa_pkg::rsp_word_t got);
    err_count++;
    if (err_count <= 10) begin
      $display("[%0d] %s: expected status %0d handle %h ctx %h, got status %0d handle %h ctx %h",
               cycle_count, what, want.status, want.handle_out, want.ctx_out,
               got.status, got.handle_out, got.ctx_out);
    end
  endfunction

  // Sampling at the rising edge: check response words, then predict accepted requests.
  always @(posedge clk) begin
    hsa_pkg::rsp_word_t got;
    hsa_pkg::rsp_word_t want;
    cycle_count++;
    if (rst) begin
      for (int unsigned k = 0; k < SLOT_COUNT; k++) begin
        tbl_valid[k]  = 1'b0;
        tbl_handle[k] = '0;
        tbl_ctx[k]    = '0;
      end
      local_cursor = 32'd1;
      node_id      = 8'd0;
    end else begin
      if (cfg_wr_en) node_id = cfg_wr_data;
      if (rsp_bus.valid && rsp_bus.ready) begin
        rsp_taken      = 1'b1;
        got.status     = rsp_bus.status;
        got.handle_out = rsp_bus.handle_out;
        got.ctx_out    = rsp_bus.ctx_out;
        if (expected_rsp.size() == 0) begin
          report_mismatch("response word with none expected", '0, got);
        end else begin
          want = expected_rsp.pop_front();
          if (got.status !== want.status || got.handle_out !== want.handle_out ||
              got.ctx_out !== want.ctx_out) begin
            report_mismatch("response word mismatch", want, got);
          end
        end
      end
      if (req_bus.valid && req_bus.ready) begin
        req_taken = 1'b1;
        expected_rsp.push_back(predict_table_op(hsa_pkg::cmd_t'(req_bus.cmd),
                                                req_bus.ctx_value, req_bus.thread_id,
                                                req_bus.handle_in));
        void'(req_backlog.pop_front());
      end
    end
  end

  // Request driver: offers the oldest pending word after a random gap.
  always @(negedge clk) begin
    logic next_valid;
    next_valid = req_bus.valid;
    if (rst) begin
      next_valid = 1'b0;
    end else begin
      if (req_taken) begin
        req_taken  = 1'b0;
        next_valid = 1'b0;
        req_gap    = pick_gap(req_calm);
      end
      if (!next_valid) begin
        if (req_gap > 0) begin
          req_gap--;
        end else if (req_backlog.size() > 0) begin
          next_valid        = 1'b1;
          req_bus.cmd       <= req_backlog[0].op;
          req_bus.ctx_value <= req_backlog[0].ctx;
          req_bus.thread_id <= req_backlog[0].thread;
          req_bus.handle_in <= req_backlog[0].handle;
        end
      end
    end
    req_bus.valid <= next_valid;
  end

  // Response side: random stalls, plus a long hold-off when one is requested.
  always @(negedge clk) begin
    if (rst) begin
      rsp_bus.ready <= 1'b0;
    end else if (rsp_hold_left > 0) begin
      rsp_hold_left--;
      rsp_bus.ready <= 1'b0;
    end else begin
      if (rsp_taken) begin
        rsp_taken = 1'b0;
        rsp_stall = pick_gap(rsp_calm);
      end
      if (rsp_stall > 0) begin
        rsp_stall--;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  // Guard against a hung block.
  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d words still expected",
               cycle_count, expected_rsp.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // Queues one request word, keeping the backlog short so stimulus tracks the table.
  task automatic queue_req(input hsa_pkg::cmd_t op, input logic [31:0] ctx,
                           input logic [7:0] thread, input logic [47:0] handle);
    table_req_t t;
    while (req_backlog.size() >= BACKLOG_MAX) @(posedge clk);
    t.op     = op;
    t.ctx    = ctx;
    t.thread = thread;
    t.handle = handle;
    req_backlog.push_back(t);
  endtask

  task automatic wait_idle();
    while (req_backlog.size() != 0 || expected_rsp.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_node_id(input logic [7:0] v);
    wait_idle();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Looks for a live handle starting from a random slot.
  function automatic bit pick_live(output logic [47:0] h, output logic [31:0] c);
    int unsigned start;
    int unsigned s;
    start = $urandom_range(0, SLOT_COUNT - 1);
    h     = rand48();
    c     = $urandom;
    for (int unsigned k = 0; k < SLOT_COUNT; k++) begin
      s = (start + k) % SLOT_COUNT;
      if (tbl_valid[s]) begin
        h = tbl_handle[s];
        c = tbl_ctx[s];
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Mixed traffic: registers, operations on live handles, near misses and noise.
  task automatic queue_mixed(input int n, input int hold_at);
    int          r;
    logic [47:0] h;
    logic [31:0] c;
    for (int k = 0; k < n; k++) begin
      if (k == hold_at) rsp_hold_left = 400;
      r = $urandom_range(0, 99);
      void'(pick_live(h, c));
      if (r < 30) begin
        queue_req(hsa_pkg::CMD_REG, $urandom, 8'($urandom), rand48());
      end else if (r < 50) begin
        queue_req(hsa_pkg::CMD_GRAB, $urandom, 8'($urandom), h);
      end else if (r < 63) begin
        queue_req(hsa_pkg::CMD_RETIRE, $urandom, 8'($urandom), h);
      end else if (r < 72) begin
        queue_req(hsa_pkg::CMD_ADD, $urandom, 8'($urandom), rand48());
      end else if (r < 78) begin
        queue_req(hsa_pkg::CMD_ADD, $urandom, 8'($urandom), h);
      end else if (r < 86) begin
        // Same slot, different upper bits: must miss.
        h[47:32] = h[47:32] ^ 16'($urandom_range(1, 16'hFFFF));
        queue_req($urandom_range(0, 1) ? hsa_pkg::CMD_GRAB : hsa_pkg::CMD_RETIRE,
                  $urandom, 8'($urandom), h);
      end else begin
        queue_req(hsa_pkg::cmd_t'($urandom_range(0, 3)), $urandom, 8'($urandom), rand48());
      end
    end
  endtask

  initial begin
    logic [47:0] h;
    logic [31:0] c;
    req_bus.valid     = 1'b0;
    req_bus.cmd       = hsa_pkg::CMD_REG;
    req_bus.ctx_value = '0;
    req_bus.thread_id = '0;
    req_bus.handle_in = '0;
    rsp_bus.ready     = 1'b0;
    cfg_wr_en         = 1'b0;
    cfg_wr_data       = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Let the clearing pass finish before touching the node number.
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    write_node_id(8'hFF);

    // Directed: both extremes of each field and every status of add, grab and retire.
    queue_req(hsa_pkg::CMD_REG,    32'h0000_0000, 8'h00, rand48());
    queue_req(hsa_pkg::CMD_REG,    32'hFFFF_FFFF, 8'hFF, rand48());
    queue_req(hsa_pkg::CMD_GRAB,   $urandom, 8'h00, 48'hFF00_0000_0001);
    queue_req(hsa_pkg::CMD_GRAB,   $urandom, 8'hFF, 48'hFFFF_0000_0002);
    queue_req(hsa_pkg::CMD_GRAB,   $urandom, 8'h00, 48'hFF01_0000_0001);
    queue_req(hsa_pkg::CMD_GRAB,   $urandom, 8'h00, 48'h7FFF_0000_0002);
    queue_req(hsa_pkg::CMD_ADD,    $urandom, 8'h00, 48'hFF00_0000_0001);
    queue_req(hsa_pkg::CMD_ADD,    $urandom, 8'h00, 48'h0000_0000_0001);
    queue_req(hsa_pkg::CMD_ADD,    32'h5A5A_5A5A, 8'hFF, 48'hFFFF_FFFF_FFFF);
    queue_req(hsa_pkg::CMD_GRAB,   $urandom, 8'h00, 48'hFFFF_FFFF_FFFF);
    queue_req(hsa_pkg::CMD_ADD,    $urandom, 8'h00, 48'hFFFF_FFFF_FFFF);
    queue_req(hsa_pkg::CMD_RETIRE, $urandom, 8'h00, 48'hFFFF_FFFF_FFFF);
    queue_req(hsa_pkg::CMD_RETIRE, $urandom, 8'h00, 48'hFFFF_FFFF_FFFF);
    queue_req(hsa_pkg::CMD_GRAB,   $urandom, 8'h00, 48'hFFFF_FFFF_FFFF);
    queue_req(hsa_pkg::CMD_GRAB,   $urandom, 8'h00, 48'h0000_0000_0000);
    queue_req(hsa_pkg::CMD_RETIRE, $urandom, 8'h00, 48'h0000_0000_0000);
    queue_req(hsa_pkg::CMD_ADD,    32'hFFFF_FFFF, 8'h00, 48'h0000_0000_0000);
    queue_req(hsa_pkg::CMD_GRAB,   $urandom, 8'h00, 48'h0000_0000_0000);
    queue_req(hsa_pkg::CMD_RETIRE, $urandom, 8'h00, 48'hFF00_0000_0001);
    queue_req(hsa_pkg::CMD_GRAB,   $urandom, 8'h00, 48'hFF00_0000_0001);
    queue_req(hsa_pkg::CMD_REG,    $urandom, 8'hA5, rand48());
    queue_req(hsa_pkg::CMD_ADD,    $urandom, 8'h00, 48'h0000_0000_0401);
    queue_req(hsa_pkg::CMD_REG,    $urandom, 8'h5A, 48'hFFFF_FFFF_FFFF);

    // Mixed traffic with a long response hold-off partway through.
    write_node_id(8'h00);
    queue_mixed(200, 60);

    // The sender pauses until every response has come back.
    wait_idle();
    write_node_id(8'($urandom));
    queue_mixed(100, -1);

    // Occupy a stretch of slots ahead of the running index, then register across it.
    write_node_id(8'h80);
    for (int k = 0; k < 48; k++) begin
      h = rand48();
      h[SLOT_BITS-1:0] = SLOT_BITS'(local_cursor + 32'(k));
      queue_req(hsa_pkg::CMD_ADD, $urandom, 8'($urandom), h);
    end
    for (int k = 0; k < 4; k++) begin
      queue_req(hsa_pkg::CMD_REG, $urandom, 8'($urandom), rand48());
    end
    for (int k = 0; k < 6; k++) begin
      void'(pick_live(h, c));
      queue_req(hsa_pkg::CMD_GRAB, $urandom, 8'($urandom), h);
      h[47:SLOT_BITS] = h[47:SLOT_BITS] ^ 38'($urandom_range(1, 1000));
      queue_req(hsa_pkg::CMD_ADD, $urandom, 8'($urandom), h);
    end

    // Punch holes into the table so registers probe through taken slots.
    wait_idle();
    for (int k = 0; k < 30; k++) begin
      void'(pick_live(h, c));
      queue_req(hsa_pkg::CMD_RETIRE, $urandom, 8'($urandom), h);
      wait_idle();
    end
    for (int k = 0; k < 34; k++) begin
      queue_req(hsa_pkg::CMD_REG, $urandom, 8'($urandom), rand48());
    end

    // Back to mixed traffic at a random node number.
    write_node_id(8'($urandom));
    queue_mixed(120, 40);

    wait_idle();
    repeat (20) @(posedge clk);
    if (err_count == 0 && expected_rsp.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

[handle_slot_allocator_unit.f]
rtl/hsa_pkg.sv
rtl/hsa_cmd_if.sv
rtl/hsa_rsp_if.sv
rtl/hsa_slot_mem.sv
rtl/hsa_ctrl.sv
rtl/handle_slot_allocator_unit.sv
rtl/hsa_checker.sv
sim/tb_top.sv
